@@ rtl/b2cc_pkg.sv @@
// Shared types and constants of the binary 2x2 cover checker.
package b2cc_pkg;

    localparam int COORD_W = 11;
    localparam int COUNT_W = 20;
    localparam int SIZE_W  = 11;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    // register index, taken from the word address bits of paddr
    typedef logic [APB_AW-3:0] t_reg_idx;
    localparam t_reg_idx REG_IMAGE_ROWS = 1'd0;
    localparam t_reg_idx REG_IMAGE_COLS = 1'd1;

    localparam logic KIND_CORNER  = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [COORD_W-1:0] corner_row;
        logic [COORD_W-1:0] corner_col;
        logic [COUNT_W-1:0] window_count;
        logic               cover_ok;
        logic               last;
    } t_result;

endpackage

@@ rtl/b2cc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module b2cc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read returns the old word on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/binary_2x2_cover_check.sv @@
// Top level of the binary 2x2 cover checker: line memories, window test, result queue.
//
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+--------------------------------------
//  pixel in | in        | i_in_valid / o_in_ready  | i_pixel
//  result   | out       | o_out_valid / i_out_ready| o_kind, o_corner_row, o_corner_col,
//           |           |                          | o_window_count, o_cover_ok, o_last
//  config   | in        | APB (psel..pready)       | image_rows @0x0, image_cols @0x4
//
//  One pixel item per cycle sustained outside the clearing pass and while the result queue
//  has room; the pace is set by the single read and single write port of each line memory,
//  used once per item. An item's results reach the output through the stage register and
//  the result queue. After reset a clearing pass writes zeros through all MAX_COLS entries
//  of the pixel line memory, during which no item is accepted (config writes still go in).
//  A two-entry result queue lets the pipe keep taking items while a result waits;
//  an item holds in the compute stage only when the queue lacks room for its results.
module binary_2x2_cover_check #(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // pixel items
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_pixel,
    // result items
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_kind,
    output logic [b2cc_pkg::COORD_W-1:0]    o_corner_row,
    output logic [b2cc_pkg::COORD_W-1:0]    o_corner_col,
    output logic [b2cc_pkg::COUNT_W-1:0]    o_window_count,
    output logic                            o_cover_ok,
    output logic                            o_last,
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [b2cc_pkg::APB_AW-1:0]     paddr,
    input  logic [b2cc_pkg::APB_DW-1:0]     pwdata,
    output logic [b2cc_pkg::APB_DW-1:0]     prdata,
    output logic                            pready
);

    localparam int CW = $clog2(MAX_COLS);
    localparam int RW = $clog2(MAX_ROWS);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [b2cc_pkg::SIZE_W-1:0] r_image_rows;
    logic [b2cc_pkg::SIZE_W-1:0] r_image_cols;
    logic                        cfg_we;
    b2cc_pkg::t_reg_idx          cfg_idx;

    assign pready  = 1'b1;
    assign cfg_we  = psel & penable & pwrite;
    assign cfg_idx = paddr[b2cc_pkg::APB_AW-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_rows <= b2cc_pkg::SIZE_W'(1);
            r_image_cols <= b2cc_pkg::SIZE_W'(1);
        end else if (cfg_we) begin
            case (cfg_idx)
                b2cc_pkg::REG_IMAGE_ROWS: r_image_rows <= pwdata[b2cc_pkg::SIZE_W-1:0];
                b2cc_pkg::REG_IMAGE_COLS: r_image_cols <= pwdata[b2cc_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            b2cc_pkg::REG_IMAGE_ROWS: prdata = b2cc_pkg::APB_DW'(r_image_rows);
            b2cc_pkg::REG_IMAGE_COLS: prdata = b2cc_pkg::APB_DW'(r_image_cols);
            default:                  prdata = '0;
        endcase
    end

    // Sizes clamped to 1..MAX, kept as last index
    logic [31:0]   rows_ext, cols_ext, rows_cl, cols_cl, rows_m1_full, cols_m1_full;
    logic [RW-1:0] rows_m1;
    logic [CW-1:0] cols_m1;

    assign rows_ext     = 32'(r_image_rows);
    assign cols_ext     = 32'(r_image_cols);
    assign rows_cl      = (rows_ext == 32'd0) ? 32'd1 :
                          (rows_ext > 32'(MAX_ROWS)) ? 32'(MAX_ROWS) : rows_ext;
    assign cols_cl      = (cols_ext == 32'd0) ? 32'd1 :
                          (cols_ext > 32'(MAX_COLS)) ? 32'(MAX_COLS) : cols_ext;
    assign rows_m1_full = rows_cl - 32'd1;
    assign cols_m1_full = cols_cl - 32'd1;
    assign rows_m1      = rows_m1_full[RW-1:0];
    assign cols_m1      = cols_m1_full[CW-1:0];

    // ------------------------------------------------------------------
    // Accept side: position counters and memory read issue
    // ------------------------------------------------------------------
    logic          r_clr_busy;
    logic [CW-1:0] r_clr_addr;
    logic [RW-1:0] r_i;
    logic [CW-1:0] r_j;
    logic          in_accept;
    logic          row_end0, last_row0;
    logic          s1_go;

    logic          r_s1_v;
    logic          r_s1_p;
    logic [RW-1:0] r_s1_i;
    logic [CW-1:0] r_s1_j;
    logic          r_s1_rend;
    logic          r_s1_lrow;
    logic          r_fwd_pix_v, r_fwd_pix_d;
    logic          r_fwd_cov_v, r_fwd_cov_d;

    assign o_in_ready = ~r_clr_busy & (~r_s1_v | s1_go);
    assign in_accept  = i_in_valid & o_in_ready;
    assign row_end0   = (r_j >= cols_m1);
    assign last_row0  = (r_i >= rows_m1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i <= '0;
            r_j <= '0;
        end else if (in_accept) begin
            if (row_end0) begin
                r_j <= '0;
                r_i <= last_row0 ? '0 : r_i + RW'(1);
            end else begin
                r_j <= r_j + CW'(1);
            end
        end
    end

    // Clearing pass over the pixel line memory
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + CW'(1);
            if (r_clr_addr == CW'(MAX_COLS - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Line memories
    //   pixel mem: pixel of the row above, per column
    //   cover mem: coverage of the row above by that row's own windows
    // Cover entries beyond the previous row's length are stale and masked.
    // ------------------------------------------------------------------
    logic          pix_we, pix_wdata, pix_rdata;
    logic [CW-1:0] pix_waddr;
    logic          cov_we, cov_wdata, cov_rdata;
    logic [CW-1:0] cov_waddr;

    b2cc_ram #(.WIDTH(1), .DEPTH(MAX_COLS)) u_pix_ram (
        .i_clk   (i_clk),
        .i_we    (pix_we),
        .i_waddr (pix_waddr),
        .i_wdata (pix_wdata),
        .i_re    (in_accept),
        .i_raddr (r_j),
        .o_rdata (pix_rdata)
    );

    b2cc_ram #(.WIDTH(1), .DEPTH(MAX_COLS)) u_cov_ram (
        .i_clk   (i_clk),
        .i_we    (cov_we),
        .i_waddr (cov_waddr),
        .i_wdata (cov_wdata),
        .i_re    (in_accept),
        .i_raddr (r_j),
        .o_rdata (cov_rdata)
    );

    // ------------------------------------------------------------------
    // Compute stage
    // ------------------------------------------------------------------
    logic                           r_left, r_diag, r_ca_prev, r_win_prev, r_uncov;
    logic [b2cc_pkg::COUNT_W-1:0]   r_count;
    logic [CW-1:0]                  r_prev_last;
    logic                           r_pend_v, r_pend_d;
    logic [CW-1:0]                  r_pend_addr;

    logic                           above, cov_raw, ca, has_up, has_left, win, err;
    logic                           img_end, win_or_prev;
    logic [CW-1:0]                  s1_jm1;
    logic [b2cc_pkg::COUNT_W-1:0]   cnt_new;
    logic [1:0]                     nres;
    logic [31:0]                    row_ext, col_ext;
    b2cc_pkg::t_result              res_win, res_ver, res0, res1;

    assign above       = r_fwd_pix_v ? r_fwd_pix_d : pix_rdata;
    assign cov_raw     = r_fwd_cov_v ? r_fwd_cov_d : cov_rdata;
    assign ca          = cov_raw & (r_s1_j <= r_prev_last);
    assign has_up      = (r_s1_i != '0);
    assign has_left    = (r_s1_j != '0);
    assign s1_jm1      = r_s1_j - CW'(1);
    assign win         = has_up & has_left & r_diag & above & r_left & r_s1_p;
    assign win_or_prev = r_win_prev | win;
    assign img_end     = r_s1_rend & r_s1_lrow;

    // a filled pixel is judged once no later window can reach it
    assign err = (has_up & has_left & r_diag & ~(r_ca_prev | win_or_prev))
               | (has_up & r_s1_rend & above & ~(ca | win))
               | (r_s1_lrow & has_left & r_left & ~win_or_prev)
               | (img_end & r_s1_p & ~win);

    assign cnt_new = r_count + b2cc_pkg::COUNT_W'(win);
    assign nres    = {1'b0, win} + {1'b0, img_end};
    assign row_ext = 32'(r_s1_i);
    assign col_ext = 32'(r_s1_j);

    always_comb begin
        res_win.kind         = b2cc_pkg::KIND_CORNER;
        res_win.corner_row   = row_ext[b2cc_pkg::COORD_W-1:0];
        res_win.corner_col   = col_ext[b2cc_pkg::COORD_W-1:0];
        res_win.window_count = cnt_new;
        res_win.cover_ok     = ~r_uncov;
        res_win.last         = 1'b0;
        res_ver.kind         = b2cc_pkg::KIND_VERDICT;
        res_ver.corner_row   = '0;
        res_ver.corner_col   = '0;
        res_ver.window_count = cnt_new;
        res_ver.cover_ok     = ~(r_uncov | err);
        res_ver.last         = 1'b1;
        res0                 = win ? res_win : res_ver;
        res1                 = res_ver;
    end

    // ------------------------------------------------------------------
    // Result queue, two entries
    // ------------------------------------------------------------------
    b2cc_pkg::t_result r_q0, r_q1, n_q0, n_q1;
    logic [1:0]        r_qcnt, n_qcnt, space, cnt_after, push;
    logic              pop;

    assign pop       = (r_qcnt != 2'd0) & i_out_ready;
    assign space     = 2'd2 - r_qcnt + 2'(pop);
    assign s1_go     = r_s1_v & (nres <= space);
    assign push      = s1_go ? nres : 2'd0;
    assign cnt_after = r_qcnt - 2'(pop);
    assign n_qcnt    = cnt_after + push;

    always_comb begin
        n_q0 = r_q0;
        n_q1 = r_q1;
        case (cnt_after)
            2'd0: begin
                n_q0 = res0;
                n_q1 = res1;
            end
            2'd1: begin
                n_q0 = pop ? r_q1 : r_q0;
                n_q1 = res0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qcnt <= 2'd0;
        end else begin
            r_qcnt <= n_qcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q0 <= n_q0;
        r_q1 <= n_q1;
    end

    assign o_out_valid    = (r_qcnt != 2'd0);
    assign o_kind         = r_q0.kind;
    assign o_corner_row   = r_q0.corner_row;
    assign o_corner_col   = r_q0.corner_col;
    assign o_window_count = r_q0.window_count;
    assign o_cover_ok     = r_q0.cover_ok;
    assign o_last         = r_q0.last;

    // ------------------------------------------------------------------
    // Memory writes
    // ------------------------------------------------------------------
    assign pix_we    = r_clr_busy | s1_go;
    assign pix_waddr = r_clr_busy ? r_clr_addr : r_s1_j;
    assign pix_wdata = r_clr_busy ? 1'b0 : r_s1_p;

    // column j-1 coverage is final at column j; the row's last column goes in the cycle after
    // it leaves the stage, from the pending register, when any next item is at column 0 and writes nothing
    assign cov_we    = r_pend_v | (s1_go & has_left);
    assign cov_waddr = r_pend_v ? r_pend_addr : s1_jm1;
    assign cov_wdata = r_pend_v ? r_pend_d : win_or_prev;

    // ------------------------------------------------------------------
    // Stage register and forwarding from writes that land on the read edge
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v      <= 1'b0;
            r_fwd_pix_v <= 1'b0;
            r_fwd_cov_v <= 1'b0;
        end else begin
            r_s1_v <= in_accept | (r_s1_v & ~s1_go);
            if (in_accept) begin
                r_fwd_pix_v <= s1_go & (r_s1_j == r_j);
                r_fwd_cov_v <= (s1_go & has_left & (s1_jm1 == r_j))
                             | (s1_go & r_s1_rend & (r_s1_j == r_j))
                             | (r_pend_v & (r_pend_addr == r_j));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_p      <= i_pixel;
            r_s1_i      <= r_i;
            r_s1_j      <= r_j;
            r_s1_rend   <= row_end0;
            r_s1_lrow   <= last_row0;
            r_fwd_pix_d <= r_s1_p;
            // newest write first: this item's own late write beats an older one
            if (s1_go & has_left & (s1_jm1 == r_j)) begin
                r_fwd_cov_d <= win_or_prev;
            end else if (s1_go & r_s1_rend & (r_s1_j == r_j)) begin
                r_fwd_cov_d <= win;
            end else begin
                r_fwd_cov_d <= r_pend_d;
            end
        end
    end

    // ------------------------------------------------------------------
    // Running state, updated as an item leaves the compute stage
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left      <= 1'b0;
            r_diag      <= 1'b0;
            r_ca_prev   <= 1'b0;
            r_win_prev  <= 1'b0;
            r_uncov     <= 1'b0;
            r_count     <= '0;
            r_prev_last <= '0;
            r_pend_v    <= 1'b0;
        end else begin
            r_pend_v <= s1_go & r_s1_rend;
            if (s1_go) begin
                r_left     <= r_s1_rend ? 1'b0 : r_s1_p;
                r_diag     <= r_s1_rend ? 1'b0 : above;
                r_ca_prev  <= ca;
                r_win_prev <= win;
                if (r_s1_rend) begin
                    r_prev_last <= r_s1_j;
                end
                if (img_end) begin
                    r_uncov <= 1'b0;
                    r_count <= '0;
                end else begin
                    r_uncov <= r_uncov | err;
                    r_count <= cnt_new;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go & r_s1_rend) begin
            r_pend_addr <= r_s1_j;
            r_pend_d    <= win;
        end
    end

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qcnt != 2'd3)
        else $error("result queue overfilled");

    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !o_in_ready)
        else $error("item taken during clearing pass");

    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_v && !s1_go) |=> (r_s1_v && $stable(r_s1_j) && $stable(r_s1_i)))
        else $error("stalled item lost its position");

    a_cov_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_v |-> !(s1_go && has_left))
        else $error("cover memory write port clash");

    a_multi_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && nres == 2'd2) |-> (cnt_after == 2'd0))
        else $error("two results pushed without room");

endmodule
